// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, ck, rn, ante, cons)

`define ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

// File: hdl/u8d_pkg.sv
`default_nettype none

package u8d_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int MAX_ITEMS   = 4;
    localparam int ITEM_CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ITEM_IDX_W  = $clog2(MAX_ITEMS);
    localparam int HELD_DEPTH  = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] CONT_BITS  = 8'h3F;
    localparam logic [7:0] LEAD2_BITS = 8'h1F;
    localparam logic [7:0] LEAD3_BITS = 8'h0F;
    localparam logic [7:0] LEAD4_BITS = 8'h07;

    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_1   = 3'd1;
    localparam logic [2:0] LEN_2   = 3'd2;
    localparam logic [2:0] LEN_3   = 3'd3;
    localparam logic [2:0] LEN_4   = 3'd4;

    typedef struct packed {
        logic        bad;
        logic [7:0]  raw;
        logic [20:0] cp;
        logic [2:0]  len;
    } item_t;

    typedef struct packed {
        item_t [MAX_ITEMS-1:0]   items;
        logic [ITEM_CNT_W-1:0]   count;
        logic                    eot;
    } job_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b <= ASCII_MAX)
            len = LEN_1;
        else if ((b & LEAD2_MASK) == LEAD2_TAG)
            len = LEN_2;
        else if ((b & LEAD3_MASK) == LEAD3_TAG)
            len = LEN_3;
        else if ((b & LEAD4_MASK) == LEAD4_TAG)
            len = LEN_4;
        else
            len = LEN_BAD;
        return len;
    endfunction

    function automatic logic [20:0] decode_cp(
        input logic [2:0] exp_len,
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b
    );
        logic [20:0] cp;
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [7:0]  m2;
        logic [7:0]  mb;
        m1 = b1 & CONT_BITS;
        m2 = b2 & CONT_BITS;
        mb = b & CONT_BITS;
        if (exp_len == LEN_2) begin
            m0 = b0 & LEAD2_BITS;
            cp = {10'd0, m0[4:0], mb[5:0]};
        end
        else if (exp_len == LEN_3) begin
            m0 = b0 & LEAD3_BITS;
            cp = {5'd0, m0[3:0], m1[5:0], mb[5:0]};
        end
        else begin
            m0 = b0 & LEAD4_BITS;
            cp = {m0[2:0], m1[5:0], m2[5:0], mb[5:0]};
        end
        return cp;
    endfunction

endpackage

`default_nettype wire

// File: hdl/u8d_byte_if.sv
`default_nettype none

interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// File: hdl/u8d_char_if.sv
`default_nettype none

interface u8d_char_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  seq_bytes;
    logic        bad_byte_flag;
    logic [7:0]  raw_byte;
    logic [31:0] char_index;
    logic        all_valid;
    logic        last_item;

    modport source (
        output valid, output code_point, output seq_bytes, output bad_byte_flag,
        output raw_byte, output char_index, output all_valid, output last_item,
        input ready
    );
    modport sink (
        input valid, input code_point, input seq_bytes, input bad_byte_flag,
        input raw_byte, input char_index, input all_valid, input last_item,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/u8d_front.sv
`default_nettype none
`include "assert_macros.svh"

module u8d_front (
    input  wire logic    clk,
    input  wire logic    rst_n,
    u8d_byte_if.sink     bytes,
    output u8d_pkg::job_t push_data,
    output logic         push_valid,
    input  wire logic    push_ready
);
    import u8d_pkg::*;

    logic [7:0] held_reg [HELD_DEPTH];
    logic [7:0] held_next [HELD_DEPTH];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] exp_len_reg;
    logic [2:0] exp_len_next;

    logic                  accept;
    logic                  is_cont;
    logic [2:0]            len;
    logic [ITEM_CNT_W-1:0] n;
    job_t                  job;

    assign accept       = bytes.valid && push_ready;
    assign bytes.ready  = push_ready;
    assign is_cont      = (bytes.in_byte & CONT_MASK) == CONT_TAG;

    always_comb
    begin
        job             = '0;
        n               = '0;
        held_next       = held_reg;
        held_count_next = held_count_reg;
        exp_len_next    = exp_len_reg;
        len             = lead_length(bytes.in_byte);
        if (held_count_reg != 2'd0 && is_cont)
        begin
            if (3'(held_count_reg) + 3'd1 >= exp_len_reg)
            begin
                job.items[n[ITEM_IDX_W-1:0]] = '{bad: 1'b0, raw: held_reg[0],
                    cp: decode_cp(exp_len_reg, held_reg[0], held_reg[1], held_reg[2],
                                  bytes.in_byte),
                    len: exp_len_reg};
                n               = n + 1'b1;
                held_count_next = 2'd0;
                exp_len_next    = 3'd0;
            end
            else if (held_count_reg != 2'd3)
            begin
                held_next[held_count_reg] = bytes.in_byte;
                held_count_next           = held_count_reg + 2'd1;
            end
        end
        else
        begin
            for (int i = 0; i < HELD_DEPTH; i++)
            begin
                if (2'(i) < held_count_reg)
                begin
                    job.items[n[ITEM_IDX_W-1:0]] = '{bad: 1'b1, raw: held_reg[i],
                                                     cp: 21'd0, len: LEN_1};
                    n = n + 1'b1;
                end
            end
            held_count_next = 2'd0;
            exp_len_next    = 3'd0;
            if (len == LEN_1)
            begin
                job.items[n[ITEM_IDX_W-1:0]] = '{bad: 1'b0, raw: bytes.in_byte,
                                                 cp: {13'd0, bytes.in_byte}, len: LEN_1};
                n = n + 1'b1;
            end
            else if (len == LEN_BAD)
            begin
                job.items[n[ITEM_IDX_W-1:0]] = '{bad: 1'b1, raw: bytes.in_byte,
                                                 cp: 21'd0, len: LEN_1};
                n = n + 1'b1;
            end
            else
            begin
                held_next[0]    = bytes.in_byte;
                held_count_next = 2'd1;
                exp_len_next    = len;
            end
        end
        if (bytes.end_of_text)
        begin
            for (int i = 0; i < HELD_DEPTH; i++)
            begin
                if (2'(i) < held_count_next)
                begin
                    job.items[n[ITEM_IDX_W-1:0]] = '{bad: 1'b1, raw: held_next[i],
                                                     cp: 21'd0, len: LEN_1};
                    n = n + 1'b1;
                end
            end
            held_count_next = 2'd0;
            exp_len_next    = 3'd0;
        end
        job.count = n;
        job.eot   = bytes.end_of_text;
    end

    assign push_data  = job;
    assign push_valid = accept && (n != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            exp_len_reg    <= 3'd0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            exp_len_reg    <= exp_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

    `ASSERT_IMPL(a_idle_no_len, clk, rst_n, held_count_reg == 2'd0, exp_len_reg == 3'd0)
    `ASSERT_IMPL(a_held_short, clk, rst_n, held_count_reg != 2'd0, 3'(held_count_reg) < exp_len_reg)
    `ASSERT_NEXT(a_eot_clears, clk, rst_n, accept && bytes.end_of_text, held_count_reg == 2'd0)

endmodule

`default_nettype wire

// File: hdl/u8d_queue.sv
`default_nettype none
`include "assert_macros.svh"

module u8d_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire u8d_pkg::job_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output u8d_pkg::job_t      pop_data
);
    import u8d_pkg::*;

    job_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `ASSERT_IMPL(a_pop_not_empty, clk, rst_n, do_pop, count_reg != '0)
    `ASSERT_IMPL(a_push_not_full, clk, rst_n, do_push, count_reg != CNT_FULL)

endmodule

`default_nettype wire

// File: hdl/u8d_back.sv
`default_nettype none
`include "assert_macros.svh"

module u8d_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire u8d_pkg::job_t job,
    u8d_char_if.source         chars
);
    import u8d_pkg::*;

    logic [ITEM_IDX_W-1:0]  idx_reg;
    logic [ITEM_IDX_W-1:0]  idx_next;
    logic [COUNT_WIDTH-1:0] counter_reg;
    logic [COUNT_WIDTH-1:0] counter_next;
    logic                   valid_so_far_reg;
    logic                   valid_so_far_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic [20:0] cp_reg;
    logic [2:0]  len_reg;
    logic        bad_reg;
    logic [7:0]  raw_reg;
    logic [31:0] index_reg;
    logic        all_valid_reg;
    logic        last_reg;

    item_t cur;
    logic  advance;
    logic  is_last;

    assign cur       = job.items[idx_reg];
    assign advance   = job_valid && (!out_valid_reg || chars.ready);
    assign is_last   = ITEM_CNT_W'(idx_reg) + 1'b1 == job.count;
    assign job_ready = advance && is_last;

    always_comb
    begin
        idx_next          = idx_reg;
        counter_next      = counter_reg;
        valid_so_far_next = valid_so_far_reg;
        out_valid_next    = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? '0 : idx_reg + 1'b1;
            if (is_last && job.eot)
            begin
                counter_next      = '0;
                valid_so_far_next = 1'b1;
            end
            else
            begin
                counter_next      = counter_reg + 1'b1;
                valid_so_far_next = valid_so_far_reg && !cur.bad;
            end
        end
        else if (chars.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg          <= '0;
            counter_reg      <= '0;
            valid_so_far_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            idx_reg          <= idx_next;
            counter_reg      <= counter_next;
            valid_so_far_reg <= valid_so_far_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cp_reg        <= cur.cp;
            len_reg       <= cur.len;
            bad_reg       <= cur.bad;
            raw_reg       <= cur.raw;
            index_reg     <= 32'(counter_reg);
            all_valid_reg <= valid_so_far_reg && !cur.bad;
            last_reg      <= is_last;
        end
    end

    assign chars.valid         = out_valid_reg;
    assign chars.code_point    = cp_reg;
    assign chars.seq_bytes     = len_reg;
    assign chars.bad_byte_flag = bad_reg;
    assign chars.raw_byte      = raw_reg;
    assign chars.char_index    = index_reg;
    assign chars.all_valid     = all_valid_reg;
    assign chars.last_item     = last_reg;

    `ASSERT_IMPL(a_bad_clears_valid, clk, rst_n, out_valid_reg && bad_reg, !all_valid_reg)
    `ASSERT_IMPL(a_idx_in_job, clk, rst_n, job_valid, ITEM_CNT_W'(idx_reg) < job.count)
    `ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid_reg && !chars.ready, out_valid_reg && $stable(cp_reg))

endmodule

`default_nettype wire

// File: hdl/utf8_stream_decoder.sv
// UTF-8 stream decoder.
// bytes: one raw byte per beat, with end_of_text set on the final byte of a string.
// chars: one beat per decoded character or per undecodable byte; last_item marks
//   the final beat caused by one input byte. A byte may cause zero to four beats.
// The front stage classifies each byte against the held partial sequence and
//   posts a job of up to four result items into a two-entry job queue; the back
//   stage plays each job out into the output register, one item per cycle unless chars
//   stalls, and keeps the running char_index and the sticky all_valid flag.
// Path: each byte's results are written into the job queue, then taken by the back
//   stage into its output register, from which chars reads them.
// Throughput: one byte per cycle while each byte yields at most one result and chars
//   is ready; a byte with several results holds the back stage until all are played out.
// Reset: no bytes held, char_index restarts at 0, all_valid at 1, output empty.
// When chars stalls, the output register holds its beat, the job queue fills,
//   and bytes.ready drops once the queue is full; nothing is lost.
`default_nettype none

module utf8_stream_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    u8d_byte_if.sink   bytes,
    u8d_char_if.source chars
);
    import u8d_pkg::*;

    job_t push_data;
    logic push_valid;
    logic push_ready;
    job_t pop_data;
    logic pop_valid;
    logic pop_ready;

    u8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    u8d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    u8d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_data),
        .chars     (chars)
    );

endmodule

`default_nettype wire

// File: dv/utf8_stream_decoder_tb.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

    import u8d_pkg::*;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  seq_bytes;
        logic        bad_byte_flag;
        logic [7:0]  raw_byte;
        logic [31:0] char_index;
        logic        all_valid;
        logic        last_item;
    } char_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
        logic       typed;
        char_t      want;
    } row_t;

    localparam int NUM_ROWS     = 25;
    localparam int RANDOM_BYTES = 500;
    localparam int QUIET_AFTER  = 450;

    logic clk;
    logic rst_n;

    u8d_byte_if bytes_if ();
    u8d_char_if chars_if ();

    utf8_stream_decoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes_if),
        .chars (chars_if)
    );

    logic [7:0]             held [3];
    logic [1:0]             held_n;
    logic [2:0]             seq_len;
    logic [COUNT_WIDTH-1:0] char_count;
    logic                   string_ok;

    char_t new_chars [$];
    char_t pending_chars [$];
    row_t  directed_rows [NUM_ROWS];
    int    err_count;
    bit    quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** utf8_stream_decoder: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        err_count++;
    endtask

    function automatic void add_char(input logic [20:0] cp, input logic [2:0] n,
                                     input logic bad, input logic [7:0] raw);
        char_t c;
        if (bad)
            string_ok = 1'b0;
        c.code_point    = bad ? 21'd0 : cp;
        c.seq_bytes     = bad ? LEN_1 : n;
        c.bad_byte_flag = bad;
        c.raw_byte      = raw;
        c.char_index    = 32'(char_count);
        c.all_valid     = string_ok;
        c.last_item     = 1'b0;
        new_chars.push_back(c);
        char_count = char_count + 1'b1;
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < int'(held_n); i++)
            add_char(21'd0, LEN_1, 1'b1, held[i]);
        held_n  = 2'd0;
        seq_len = LEN_BAD;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eot);
        logic [20:0] cp;
        logic [2:0]  len;
        new_chars.delete();
        if (held_n != 2'd0 && (b & CONT_MASK) == CONT_TAG)
        begin
            if (int'(held_n) + 1 >= int'(seq_len))
            begin
                if (seq_len == LEN_2)
                    cp = {10'd0, held[0][4:0], b[5:0]};
                else if (seq_len == LEN_3)
                    cp = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
                else
                    cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
                add_char(cp, seq_len, 1'b0, held[0]);
                held_n  = 2'd0;
                seq_len = LEN_BAD;
            end
            else
            begin
                held[held_n] = b;
                held_n       = held_n + 2'd1;
            end
        end
        else
        begin
            if (held_n != 2'd0)
                flush_held();
            casez (b)
                8'b0???????: len = LEN_1;
                8'b110?????: len = LEN_2;
                8'b1110????: len = LEN_3;
                8'b11110???: len = LEN_4;
                default:     len = LEN_BAD;
            endcase
            if (len == LEN_1)
                add_char({13'd0, b}, LEN_1, 1'b0, b);
            else if (len == LEN_BAD)
                add_char(21'd0, LEN_1, 1'b1, b);
            else
            begin
                held[0] = b;
                held_n  = 2'd1;
                seq_len = len;
            end
        end
        if (eot)
            flush_held();
        if (new_chars.size() > 0)
            new_chars[new_chars.size() - 1].last_item = 1'b1;
        if (eot)
        begin
            char_count = '0;
            string_ok  = 1'b1;
        end
    endfunction

    task automatic send_byte(input row_t row);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            bytes_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        bytes_if.valid       <= 1'b1;
        bytes_if.in_byte     <= row.data;
        bytes_if.end_of_text <= row.eot;
        @(posedge clk);
        while (!bytes_if.ready)
            @(posedge clk);
        decode_byte(row.data, row.eot);
        if (row.typed)
            pending_chars.push_back(row.want);
        else
            foreach (new_chars[i])
                pending_chars.push_back(new_chars[i]);
    endtask

    initial
    begin
        chars_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            chars_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!quiet)
            begin
                chars_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        char_t want;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected beat, code_point %h raw_byte %h",
                                          chars_if.code_point, chars_if.raw_byte));
            else
            begin
                want = pending_chars.pop_front();
                if (chars_if.code_point !== want.code_point)
                    report_mismatch($sformatf("code_point got %h want %h",
                                              chars_if.code_point, want.code_point));
                if (chars_if.seq_bytes !== want.seq_bytes)
                    report_mismatch($sformatf("seq_bytes got %0d want %0d",
                                              chars_if.seq_bytes, want.seq_bytes));
                if (chars_if.bad_byte_flag !== want.bad_byte_flag)
                    report_mismatch($sformatf("bad_byte_flag got %b want %b",
                                              chars_if.bad_byte_flag, want.bad_byte_flag));
                if (chars_if.raw_byte !== want.raw_byte)
                    report_mismatch($sformatf("raw_byte got %h want %h",
                                              chars_if.raw_byte, want.raw_byte));
                if (chars_if.char_index !== want.char_index)
                    report_mismatch($sformatf("char_index got %0d want %0d",
                                              chars_if.char_index, want.char_index));
                if (chars_if.all_valid !== want.all_valid)
                    report_mismatch($sformatf("all_valid got %b want %b",
                                              chars_if.all_valid, want.all_valid));
                if (chars_if.last_item !== want.last_item)
                    report_mismatch($sformatf("last_item got %b want %b",
                                              chars_if.last_item, want.last_item));
            end
        end
    end

    initial
    begin
        logic [7:0] seq_q [$];
        row_t       row;
        int         kind;
        int         n;
        int         sent;

        err_count  = 0;
        quiet      = 1'b0;
        held_n     = 2'd0;
        seq_len    = LEN_BAD;
        char_count = '0;
        string_ok  = 1'b1;

        directed_rows = '{
            '{8'h00, 1'b0, 1'b1, '{21'h0, LEN_1, 1'b0, 8'h00, 32'd0, 1'b1, 1'b1}},
            '{8'h7F, 1'b0, 1'b1, '{21'h7F, LEN_1, 1'b0, 8'h7F, 32'd1, 1'b1, 1'b1}},
            '{8'hC3, 1'b0, 1'b0, '0},
            '{8'hA9, 1'b0, 1'b0, '0},
            '{8'hEF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hF7, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b0, '0},
            '{8'hBF, 1'b0, 1'b1, '{21'h1FFFFF, LEN_4, 1'b0, 8'hF7, 32'd4, 1'b1, 1'b1}},
            '{8'h80, 1'b0, 1'b1, '{21'h0, LEN_1, 1'b1, 8'h80, 32'd5, 1'b0, 1'b1}},
            '{8'hFF, 1'b0, 1'b1, '{21'h0, LEN_1, 1'b1, 8'hFF, 32'd6, 1'b0, 1'b1}},
            '{8'hE2, 1'b0, 1'b0, '0},
            '{8'h41, 1'b0, 1'b0, '0},
            '{8'hF0, 1'b0, 1'b0, '0},
            '{8'h9F, 1'b0, 1'b0, '0},
            '{8'h80, 1'b0, 1'b0, '0},
            '{8'h42, 1'b0, 1'b0, '0},
            '{8'hC3, 1'b1, 1'b0, '0},
            '{8'h41, 1'b1, 1'b1, '{21'h41, LEN_1, 1'b0, 8'h41, 32'd0, 1'b1, 1'b1}},
            '{8'hE2, 1'b0, 1'b0, '0},
            '{8'h82, 1'b1, 1'b0, '0},
            '{8'hC0, 1'b0, 1'b0, '0},
            '{8'h80, 1'b1, 1'b0, '0}
        };

        rst_n                <= 1'b0;
        bytes_if.valid       <= 1'b0;
        bytes_if.in_byte     <= 8'h00;
        bytes_if.end_of_text <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
            send_byte(directed_rows[i]);

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            seq_q.delete();
            kind = $urandom_range(0, 99);
            n    = $urandom_range(1, 4);
            if (kind < 85)
            begin
                case (n)
                    1:       seq_q.push_back(8'($urandom_range(0, 127)));
                    2:       seq_q.push_back(LEAD2_TAG | 8'($urandom_range(0, 31)));
                    3:       seq_q.push_back(LEAD3_TAG | 8'($urandom_range(0, 15)));
                    default: seq_q.push_back(LEAD4_TAG | 8'($urandom_range(0, 7)));
                endcase
                for (int k = 1; k < n; k++)
                    seq_q.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
                // drop the tail to break the sequence
                if (kind >= 70 && n > 1)
                    seq_q = seq_q[0:$urandom_range(0, n - 2)];
            end
            else if (kind < 93)
            begin
                if ($urandom_range(0, 1) == 0)
                    seq_q.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
                else
                    seq_q.push_back(LEAD4_MASK | 8'($urandom_range(0, 7)));
            end
            else
                seq_q.push_back(8'($urandom_range(0, 255)));

            foreach (seq_q[i])
            begin
                row.data  = seq_q[i];
                row.eot   = ($urandom_range(0, 19) == 0);
                row.typed = 1'b0;
                row.want  = '0;
                send_byte(row);
                sent++;
                if (sent >= QUIET_AFTER)
                    quiet = 1'b1;
            end
        end
        bytes_if.valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_count == 0)
            $display("** utf8_stream_decoder: PASSED **");
        else
            $display("** utf8_stream_decoder: FAILED **");
        $finish;
    end

endmodule
